/* design/sha384_pkg.sv */
// Shared types, constants and round functions for the SHA-384 hasher.
package sha384_pkg;

   localparam int unsigned WordBits  = 64;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds    = 80;
   localparam int unsigned DigestWords = 6;

   typedef logic [WordBits-1:0] word_type;

   // One message block on its way from the front end to the compression engine.
   typedef struct packed {
      logic [BlockWords-1:0][WordBits-1:0] words;
      logic                                is_last;
   } blk_type;

   localparam word_type INIT_HASH [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
      64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
      64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

   localparam word_type ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
      64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
      64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
      64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
      64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
      64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
      64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
      64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
      64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
      64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
      64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
      64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
      64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
      64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
      64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
      64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
      64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
      64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
      64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
      64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
      64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   localparam logic [7:0] PAD_MARK = 8'h80;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WordBits - n));
   endfunction

   function automatic word_type big_s0(input word_type x);
      big_s0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_s1(input word_type x);
      big_s1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_s0(input word_type x);
      small_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_s1(input word_type x);
      small_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

/* design/sha384_front.sv */
// Front end: packs message bytes into blocks, appends padding and length.
module sha384_front import sha384_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  word_type req_tdata,   // message_word
   input  logic [3:0] req_tuser, // valid_bytes
   input  logic     req_tlast,   // end_of_message
   output logic     push,
   output blk_type  push_data,
   input  logic     q_full
);

   typedef enum logic [1:0] {S_TAKE, S_PUSH, S_PAD} state_type;

   state_type            state_ff;
   logic [15:0][63:0]    buf_ff;
   logic [3:0]           wi_ff;
   word_type             acc_ff;
   logic [2:0]           acc_cnt_ff;
   logic [60:0]          cnt_ff;
   logic                 pad_pending_ff;
   logic                 mark_done_ff;
   logic                 len_ok_ff;
   logic                 push_last_ff;

   logic                 take;
   logic [3:0]           nbytes;
   logic [3:0]           total;
   word_type             wmask;
   logic [127:0]         comb_in;
   word_type             pad_word;
   logic                 pad_is_len;

   assign req_tready = (state_ff == S_TAKE);
   assign take       = req_tvalid && req_tready;

   // Clamp the byte count and join the new bytes behind the held remainder.
   always_comb begin
      nbytes  = (req_tuser > 4'd8) ? 4'd8 : req_tuser;
      total   = {1'b0, acc_cnt_ff} + nbytes;
      wmask   = req_tdata & ~(64'hFFFF_FFFF_FFFF_FFFF >> {nbytes, 3'b000});
      comb_in = {acc_ff, 64'd0} | ({wmask, 64'd0} >> {acc_cnt_ff, 3'b000});
   end

   // Word written while padding: marker word, zero fill or bit length.
   always_comb begin
      pad_is_len = 1'b0;
      if (!mark_done_ff) begin
         pad_word = acc_ff | ({56'd0, PAD_MARK} << {3'd7 - acc_cnt_ff, 3'b000});
      end else if (wi_ff == 4'd15 && len_ok_ff) begin
         pad_word   = {cnt_ff, 3'b000};
         pad_is_len = 1'b1;
      end else begin
         pad_word = '0;
      end
   end

   assign push              = (state_ff == S_PUSH) && !q_full;
   assign push_data.words   = buf_ff;
   assign push_data.is_last = push_last_ff;

   // Front sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_TAKE;
         wi_ff          <= '0;
         acc_ff         <= '0;
         acc_cnt_ff     <= '0;
         cnt_ff         <= '0;
         pad_pending_ff <= 1'b0;
         mark_done_ff   <= 1'b0;
         len_ok_ff      <= 1'b0;
         push_last_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_TAKE: begin
               if (take) begin
                  cnt_ff <= cnt_ff + 61'(nbytes);
                  if (total >= 4'd8) begin
                     buf_ff[wi_ff] <= comb_in[127:64];
                     acc_ff        <= comb_in[63:0];
                     acc_cnt_ff    <= 3'(total - 4'd8);
                     wi_ff         <= wi_ff + 4'd1;
                     if (wi_ff == 4'd15) begin
                        state_ff       <= S_PUSH;
                        pad_pending_ff <= req_tlast;
                     end else if (req_tlast) begin
                        state_ff <= S_PAD;
                     end
                  end else begin
                     acc_ff     <= comb_in[127:64];
                     acc_cnt_ff <= total[2:0];
                     if (req_tlast) begin
                        state_ff <= S_PAD;
                     end
                  end
               end
            end
            S_PUSH: begin
               if (!q_full) begin
                  wi_ff <= '0;
                  if (push_last_ff) begin
                     state_ff       <= S_TAKE;
                     cnt_ff         <= '0;
                     acc_ff         <= '0;
                     acc_cnt_ff     <= '0;
                     pad_pending_ff <= 1'b0;
                     mark_done_ff   <= 1'b0;
                     len_ok_ff      <= 1'b0;
                     push_last_ff   <= 1'b0;
                  end else if (pad_pending_ff) begin
                     state_ff <= S_PAD;
                     if (mark_done_ff) begin
                        len_ok_ff <= 1'b1;
                     end
                  end else begin
                     state_ff <= S_TAKE;
                  end
               end
            end
            S_PAD: begin
               buf_ff[wi_ff] <= pad_word;
               if (!mark_done_ff) begin
                  mark_done_ff <= 1'b1;
                  len_ok_ff    <= (wi_ff <= 4'd13);
               end
               if (wi_ff == 4'd15) begin
                  state_ff       <= S_PUSH;
                  pad_pending_ff <= 1'b1;
                  push_last_ff   <= pad_is_len;
               end else begin
                  wi_ff <= wi_ff + 4'd1;
               end
            end
            default: state_ff <= S_TAKE;
         endcase
      end
   end

endmodule

/* design/sha384_fifo.sv */
// Two-entry block queue between the front end and the compression engine.
module sha384_fifo import sha384_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  blk_type push_data,
   input  logic    pop,
   output blk_type head,
   output logic    full,
   output logic    empty
);

   blk_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* design/sha384_back.sv */
// Back end: 80-round compression, chain update and digest output register.
module sha384_back import sha384_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  blk_type  head,
   output logic     pop,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output word_type rsp_tdata,   // digest_word
   output logic     rsp_tlast    // digest_last
);

   typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_OUT} state_type;

   state_type   state_ff;
   word_type    chain_ff [8];
   word_type    work_ff  [8];
   word_type    win_ff   [16];
   logic [6:0]  t_ff;
   logic        last_ff;
   logic [2:0]  k_ff;
   logic        valid_ff;
   word_type    data_ff;
   logic        dlast_ff;

   word_type    t1;
   word_type    t2;
   word_type    w_next;
   logic        out_free;

   assign pop        = (state_ff == B_IDLE) && !q_empty;
   assign out_free   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = dlast_ff;

   // One compression round and the next schedule word.
   always_comb begin
      t1 = work_ff[7] + big_s1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + ROUND_K[t_ff] + win_ff[0];
      t2 = big_s0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]));
      w_next = small_s1(win_ff[14]) + win_ff[9] + small_s0(win_ff[1]) + win_ff[0];
   end

   // Engine sequencer with the digest output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         dlast_ff <= 1'b0;
         t_ff     <= '0;
         k_ff     <= '0;
         last_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
      end else begin
         if (valid_ff && rsp_tready && state_ff != B_OUT) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  for (int i = 0; i < 8; i++) begin
                     work_ff[i] <= chain_ff[i];
                  end
                  for (int i = 0; i < 16; i++) begin
                     win_ff[i] <= head.words[i];
                  end
                  last_ff  <= head.is_last;
                  t_ff     <= '0;
                  state_ff <= B_ROUND;
               end
            end
            B_ROUND: begin
               for (int i = 1; i < 8; i++) begin
                  if (i == 4) begin
                     work_ff[i] <= work_ff[3] + t1;
                  end else begin
                     work_ff[i] <= work_ff[i-1];
                  end
               end
               work_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) begin
                  win_ff[i] <= win_ff[i+1];
               end
               win_ff[15] <= w_next;
               t_ff <= t_ff + 7'd1;
               if (t_ff == 7'(Rounds - 1)) begin
                  state_ff <= B_ADD;
               end
            end
            B_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + work_ff[i];
               end
               k_ff     <= '0;
               state_ff <= last_ff ? B_OUT : B_IDLE;
            end
            B_OUT: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  data_ff  <= chain_ff[k_ff];
                  dlast_ff <= (k_ff == 3'(DigestWords - 1));
                  k_ff     <= k_ff + 3'd1;
                  if (k_ff == 3'(DigestWords - 1)) begin
                     state_ff <= B_IDLE;
                     for (int i = 0; i < 8; i++) begin
                        chain_ff[i] <= INIT_HASH[i];
                     end
                  end
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

/* design/sha384_message_hasher_core.sv */
// Top level of the SHA-384 message hasher.
// Usage: message words arrive on the req_ channel, eight bytes each, first byte in
// bits 63:56; req_tuser gives the byte count (above 8 counts as 8) and req_tlast
// marks the final word. Each final word yields six transfers on the rsp_
// channel, the 384-bit digest most significant word first, rsp_tlast on the sixth.
// The front end takes one word per cycle while it is not padding or pushing a
// block, packs bytes into 128-byte blocks and pads the final block, writing one
// word per cycle while padding. Full blocks wait in a two-entry queue. The
// compression engine loads a block, runs 80 rounds with one round per cycle and
// adds the result into the chain; the single round unit limits throughput.
// After reset the chain holds the initial hash values and no message is open;
// after each digest the block returns to that state by itself.
// If the receiver stalls, the output register holds its word and the engine
// waits; the front end keeps taking words until the queue fills.
module sha384_message_hasher_core import sha384_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] message_word
   input  logic [3:0]  req_tuser,   // [3:0] valid_bytes
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] digest_word
   output logic        rsp_tlast    // digest_last
);

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   blk_type q_in;
   blk_type q_head;

   sha384_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push       (q_push),
      .push_data  (q_in),
      .q_full     (q_full)
   );

   sha384_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   sha384_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The queue is never written while full nor read while empty.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full)) else $error("block queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty)) else $error("block queue read while empty");

   // A digest word is never shown in the cycle right after a block is taken.
   a_no_early_digest: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !$rose(rsp_tvalid)) else $error("digest appeared before rounds ran");

endmodule
